[rtl/core/tds_pkg.sv]
package tds_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RESIDUAL_TICKS  = 3'd0,
    REG_MELT_WAIT_TICKS = 3'd1,
    REG_CIRC_WAIT_TICKS = 3'd2,
    REG_CIRC_RUN_TICKS  = 3'd3,
    REG_CIRC_ENABLE     = 3'd4
  } cfg_reg_e;

  localparam logic [15:0] ResidualTicksRst = 16'd5400;
  localparam logic [15:0] MeltWaitTicksRst = 16'd800;
  localparam logic [15:0] CircWaitTicksRst = 16'd6000;
  localparam logic [15:0] CircRunTicksRst  = 16'd6000;
  localparam logic        CircEnableRst    = 1'b1;

  typedef enum logic [3:0] {
    STEP_READY    = 4'b0001,
    STEP_EMPTY    = 4'b0010,
    STEP_RESIDUAL = 4'b0100,
    STEP_DONE     = 4'b1000
  } step_e;

  localparam logic [1:0] PhaseReady    = 2'd0;
  localparam logic [1:0] PhaseDrain    = 2'd1;
  localparam logic [1:0] PhaseResidual = 2'd2;
  localparam logic [1:0] PhaseDone     = 2'd3;

  typedef struct packed {
    logic [15:0] residual_ticks;
    logic [15:0] melt_wait_ticks;
    logic [15:0] circ_wait_ticks;
    logic [15:0] circ_run_ticks;
    logic        circ_enable;
  } cfg_t;

  typedef struct packed {
    logic       valve_open;
    logic       drain_pump_on;
    logic       circ_pump_on;
    logic [1:0] phase;
    logic       finished;
  } result_t;

endpackage

[rtl/core/tds_cfg_regs.sv]
module tds_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tds_pkg::CfgDataW-1:0] cfg_data_i,
  output tds_pkg::cfg_t                cfg_o
);

  tds_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.residual_ticks  <= tds_pkg::ResidualTicksRst;
      cfg_q.melt_wait_ticks <= tds_pkg::MeltWaitTicksRst;
      cfg_q.circ_wait_ticks <= tds_pkg::CircWaitTicksRst;
      cfg_q.circ_run_ticks  <= tds_pkg::CircRunTicksRst;
      cfg_q.circ_enable     <= tds_pkg::CircEnableRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tds_pkg::REG_RESIDUAL_TICKS:  cfg_q.residual_ticks  <= cfg_data_i;
        tds_pkg::REG_MELT_WAIT_TICKS: cfg_q.melt_wait_ticks <= cfg_data_i;
        tds_pkg::REG_CIRC_WAIT_TICKS: cfg_q.circ_wait_ticks <= cfg_data_i;
        tds_pkg::REG_CIRC_RUN_TICKS:  cfg_q.circ_run_ticks  <= cfg_data_i;
        tds_pkg::REG_CIRC_ENABLE:     cfg_q.circ_enable     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/tds_core.sv]
module tds_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic             kind_i,
  input  logic             room_low_i,
  input  logic             cold_low_i,
  input  logic             drain_low_seen_i,
  input  logic             drain_high_seen_i,
  input  tds_pkg::cfg_t    cfg_i,
  output tds_pkg::result_t result_o
);

  tds_pkg::step_e        step_q, step_d;
  logic [TIMER_BITS-1:0] res_cnt_q, res_cnt_d;
  logic [TIMER_BITS-1:0] melt_cnt_q, melt_cnt_d;
  logic [TIMER_BITS-1:0] wait_cnt_q, wait_cnt_d;
  logic [TIMER_BITS-1:0] run_cnt_q, run_cnt_d;
  logic                  circ_act_q, circ_act_d;
  logic                  valve_q, valve_d;
  logic                  pump_q, pump_d;
  logic                  circ_q, circ_d;
  logic                  finished;
  logic                  en;

  logic [TIMER_BITS-1:0] res_load, melt_load, wait_load, run_load;

  assign res_load  = TIMER_BITS'(cfg_i.residual_ticks);
  assign melt_load = TIMER_BITS'(cfg_i.melt_wait_ticks);
  assign wait_load = TIMER_BITS'(cfg_i.circ_wait_ticks);
  assign run_load  = TIMER_BITS'(cfg_i.circ_run_ticks);
  assign en        = cfg_i.circ_enable;

  always_comb begin
    step_d     = step_q;
    res_cnt_d  = res_cnt_q;
    melt_cnt_d = melt_cnt_q;
    wait_cnt_d = wait_cnt_q;
    run_cnt_d  = run_cnt_q;
    circ_act_d = circ_act_q;
    valve_d    = valve_q;
    pump_d     = pump_q;
    circ_d     = circ_q;
    finished   = 1'b0;

    if (kind_i) begin
      step_d     = tds_pkg::STEP_READY;
      valve_d    = 1'b0;
      circ_act_d = 1'b0;
      circ_d     = 1'b0;
    end else begin
      // sequence step
      case (step_q)
        tds_pkg::STEP_READY: begin
          res_cnt_d = res_load;
          if (en) begin
            circ_act_d = 1'b1;
            wait_cnt_d = wait_load;
            run_cnt_d  = run_load;
          end
          step_d = tds_pkg::STEP_EMPTY;
        end
        tds_pkg::STEP_EMPTY: begin
          if (room_low_i && cold_low_i) begin
            res_cnt_d = res_load;
            step_d    = tds_pkg::STEP_RESIDUAL;
          end
        end
        tds_pkg::STEP_RESIDUAL: begin
          if (res_cnt_q != '0) begin
            res_cnt_d = res_cnt_q - TIMER_BITS'(1);
          end else begin
            step_d = tds_pkg::STEP_DONE;
          end
        end
        tds_pkg::STEP_DONE: begin
          if (en) begin
            circ_act_d = 1'b0;
            circ_d     = 1'b0;
          end
          finished = 1'b1;
        end
        default: step_d = tds_pkg::STEP_READY;
      endcase

      // drain valve and pump
      if (!drain_low_seen_i && !drain_high_seen_i) begin
        valve_d    = 1'b1;
        pump_d     = 1'b0;
        melt_cnt_d = melt_load;
      end else if (drain_high_seen_i) begin
        valve_d    = 1'b0;
        pump_d     = 1'b1;
        melt_cnt_d = melt_load;
      end else if (melt_cnt_q != '0) begin
        if (room_low_i) begin
          valve_d = 1'b1;
        end
        melt_cnt_d = melt_cnt_q - TIMER_BITS'(1);
      end else begin
        pump_d = 1'b1;
      end

      // circulation pump
      if (en) begin
        if (circ_act_d) begin
          if (cold_low_i || pump_d || !valve_d || drain_low_seen_i || drain_high_seen_i) begin
            wait_cnt_d = wait_load;
            run_cnt_d  = run_load;
            circ_d     = 1'b0;
          end else if (wait_cnt_d != '0) begin
            wait_cnt_d = wait_cnt_d - TIMER_BITS'(1);
          end else if (run_cnt_d != '0) begin
            run_cnt_d = run_cnt_d - TIMER_BITS'(1);
            circ_d    = 1'b1;
          end else begin
            circ_d = 1'b0;
          end
        end
      end else begin
        circ_act_d = 1'b0;
        circ_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= tds_pkg::STEP_READY;
      res_cnt_q  <= '0;
      melt_cnt_q <= '0;
      wait_cnt_q <= '0;
      run_cnt_q  <= '0;
      circ_act_q <= 1'b0;
      valve_q    <= 1'b0;
      pump_q     <= 1'b0;
      circ_q     <= 1'b0;
    end else if (fire_i) begin
      step_q     <= step_d;
      res_cnt_q  <= res_cnt_d;
      melt_cnt_q <= melt_cnt_d;
      wait_cnt_q <= wait_cnt_d;
      run_cnt_q  <= run_cnt_d;
      circ_act_q <= circ_act_d;
      valve_q    <= valve_d;
      pump_q     <= pump_d;
      circ_q     <= circ_d;
    end
  end

  always_comb begin
    case (step_d)
      tds_pkg::STEP_READY:    result_o.phase = tds_pkg::PhaseReady;
      tds_pkg::STEP_EMPTY:    result_o.phase = tds_pkg::PhaseDrain;
      tds_pkg::STEP_RESIDUAL: result_o.phase = tds_pkg::PhaseResidual;
      tds_pkg::STEP_DONE:     result_o.phase = tds_pkg::PhaseDone;
      default:                result_o.phase = tds_pkg::PhaseReady;
    endcase
    result_o.valve_open    = valve_d;
    result_o.drain_pump_on = pump_d;
    result_o.circ_pump_on  = circ_d;
    result_o.finished      = finished;
  end

endmodule

[rtl/core/tank_drain_sequencer_top.sv]
// a word accepted on the input is held in the input register, and its result
// is held in the result register until it is taken
// throughput: one word per cycle, sustained while the output is not stalled
// an input register and a result register frame one pass of next-state logic
// reset clears the sequence to ready, closes valve, stops both pumps, zeroes
// all timers and restores the configuration registers to their defaults
module tank_drain_sequencer_top #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tds_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic                         room_low_i,
  input  logic                         cold_low_i,
  input  logic                         drain_low_seen_i,
  input  logic                         drain_high_seen_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         valve_open_o,
  output logic                         drain_pump_on_o,
  output logic                         circ_pump_on_o,
  output logic [1:0]                   phase_o,
  output logic                         finished_o
);

  tds_pkg::cfg_t    cfg;
  tds_pkg::result_t result;
  tds_pkg::result_t res_q;

  logic in_vld_q;
  logic out_vld_q;
  logic kind_q, room_low_q, cold_low_q, dlow_q, dhigh_q;
  logic out_free;
  logic fire;
  logic in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  tds_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q     <= kind_i;
      room_low_q <= room_low_i;
      cold_low_q <= cold_low_i;
      dlow_q     <= drain_low_seen_i;
      dhigh_q    <= drain_high_seen_i;
    end
  end

  tds_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .fire_i            (fire),
    .kind_i            (kind_q),
    .room_low_i        (room_low_q),
    .cold_low_i        (cold_low_q),
    .drain_low_seen_i  (dlow_q),
    .drain_high_seen_i (dhigh_q),
    .cfg_i             (cfg),
    .result_o          (result)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= result;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign valve_open_o    = res_q.valve_open;
  assign drain_pump_on_o = res_q.drain_pump_on;
  assign circ_pump_on_o  = res_q.circ_pump_on;
  assign phase_o         = res_q.phase;
  assign finished_o      = res_q.finished;

endmodule
